// File: rtl/taylor_sine_cosine_assert.svh
// ----------------------------------------------------------------------------
// taylor_sine_cosine assertion macros
// Shared concurrent assertion forms for the sine/cosine pipeline.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_SINE_COSINE_ASSERT_SVH
`define TAYLOR_SINE_COSINE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define TSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Fixed-point constants, series coefficients and the cell-to-cell data type.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int ACC_W = 34;   // Horner accumulator, signed Q.30 with headroom
    localparam int X_W   = 34;   // angle or pi/2 - angle, signed Q.28
    localparam int R_W   = 31;   // reduced angle in [0, 2pi), Q.28
    localparam int Y_W   = 29;   // folded angle in [0, pi/2] plus one LSB, Q.28
    localparam int Y30_W = 31;   // folded angle, Q.30
    localparam int SQ_W  = 62;   // exact square of the folded angle
    localparam int Y2_W  = 32;   // rounded square, unsigned Q.30

    localparam logic signed [X_W-1:0] Q28_HALF_PI  = 34'sd421657428;
    localparam logic signed [X_W-1:0] Q28_PI       = 34'sd843314857;
    localparam logic signed [X_W-1:0] Q28_3HALF_PI = 34'sd1264972285;
    localparam logic signed [X_W-1:0] Q28_TWO_PI   = 34'sd1686629713;
    localparam logic signed [X_W-1:0] Q28_FOUR_PI  = 34'sd3373259426;

    localparam logic signed [ACC_W-1:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [ACC_W-1:0] Q30_NEG_ONE = -34'sd1073741824;
    localparam logic [SQ_W:0]           Q30_HALF_SQ = 63'd536870912;

    localparam int COEF_N   = 8;
    localparam int MAX_TERM = COEF_N - 1;

    // (-1)^k / (2k)! in Q.30, rounded to nearest
    localparam logic signed [ACC_W-1:0] COEF [COEF_N] = '{
        34'sd1073741824, -34'sd536870912, 34'sd44739243, -34'sd1491308,
        34'sd26631, -34'sd296, 34'sd2, 34'sd0
    };

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic [Y2_W-1:0]         y2;
        logic                    neg;
    } tsc_data_t;

endpackage

// File: rtl/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// Sine offset, reduction modulo 2pi, quadrant fold and squaring, five stages.
// ----------------------------------------------------------------------------
`include "taylor_sine_cosine_assert.svh"

module tsc_front #(
    parameter logic signed [tsc_pkg::ACC_W-1:0] INIT_COEF = '0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      in_angle,
    input  logic                    in_operation,
    output logic                    out_valid,
    input  logic                    out_ready,
    output tsc_pkg::tsc_data_t      out_data
);

    logic [4:0] vld_reg;
    logic [4:0] rdy;

    logic signed [tsc_pkg::X_W-1:0]   x_reg, x_next;
    logic [tsc_pkg::R_W-1:0]          r_reg, r_next;
    logic [tsc_pkg::Y30_W-1:0]        y30_reg, y30_next;
    logic [tsc_pkg::SQ_W-1:0]         sq_reg, sq_next;
    logic [tsc_pkg::Y2_W-1:0]         y2_reg, y2_next;
    logic [2:0]                       neg_reg;
    logic                             neg_next;

    logic signed [tsc_pkg::X_W-1:0]   a_ext, red;
    logic signed [tsc_pkg::X_W-1:0]   r_ext, y_full;
    logic [tsc_pkg::SQ_W:0]           sq_rnd;

    // stall only where the stage ahead is full and blocked
    assign rdy[4]   = !vld_reg[4] || out_ready;
    assign rdy[3]   = !vld_reg[3] || rdy[4];
    assign rdy[2]   = !vld_reg[2] || rdy[3];
    assign rdy[1]   = !vld_reg[1] || rdy[2];
    assign rdy[0]   = !vld_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    always_comb begin
        a_ext  = tsc_pkg::X_W'(in_angle);
        x_next = in_operation ? (tsc_pkg::Q28_HALF_PI - a_ext) : a_ext;

        // x lies in [-2.55pi, 3.05pi]: one of four offsets lands in [0, 2pi)
        if (x_reg >= tsc_pkg::Q28_TWO_PI) begin
            red = x_reg - tsc_pkg::Q28_TWO_PI;
        end else if (x_reg >= 0) begin
            red = x_reg;
        end else if (x_reg >= -tsc_pkg::Q28_TWO_PI) begin
            red = x_reg + tsc_pkg::Q28_TWO_PI;
        end else begin
            red = x_reg + tsc_pkg::Q28_FOUR_PI;
        end
        r_next = red[tsc_pkg::R_W-1:0];

        r_ext = tsc_pkg::X_W'({1'b0, r_reg});
        if (r_ext < tsc_pkg::Q28_HALF_PI) begin
            y_full   = r_ext;
            neg_next = 1'b0;
        end else if (r_ext < tsc_pkg::Q28_PI) begin
            y_full   = tsc_pkg::Q28_PI - r_ext;
            neg_next = 1'b1;
        end else if (r_ext < tsc_pkg::Q28_3HALF_PI) begin
            y_full   = r_ext - tsc_pkg::Q28_PI;
            neg_next = 1'b1;
        end else begin
            y_full   = tsc_pkg::Q28_TWO_PI - r_ext;
            neg_next = 1'b0;
        end
        y30_next = {y_full[tsc_pkg::Y_W-1:0], 2'b00};

        sq_next = tsc_pkg::SQ_W'(y30_reg) * tsc_pkg::SQ_W'(y30_reg);

        sq_rnd  = {1'b0, sq_reg} + tsc_pkg::Q30_HALF_SQ;
        y2_next = sq_rnd[tsc_pkg::Y2_W+29:30];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
            if (rdy[2]) vld_reg[2] <= vld_reg[1];
            if (rdy[3]) vld_reg[3] <= vld_reg[2];
            if (rdy[4]) vld_reg[4] <= vld_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) x_reg <= x_next;
        if (rdy[1] && vld_reg[0]) r_reg <= r_next;
        if (rdy[2] && vld_reg[1]) begin
            y30_reg    <= y30_next;
            neg_reg[0] <= neg_next;
        end
        if (rdy[3] && vld_reg[2]) begin
            sq_reg     <= sq_next;
            neg_reg[1] <= neg_reg[0];
        end
        if (rdy[4] && vld_reg[3]) begin
            y2_reg     <= y2_next;
            neg_reg[2] <= neg_reg[1];
        end
    end

    assign out_valid     = vld_reg[4];
    assign out_data.acc  = INIT_COEF;
    assign out_data.y2   = y2_reg;
    assign out_data.neg  = neg_reg[2];

    // the quadrant II fold of r = pi/2 gives pi - pi/2, one LSB above pi/2
    `TSC_ASSERT_NOW(a_reduced_range, aclk, aresetn, vld_reg[1],
        tsc_pkg::X_W'({1'b0, r_reg}) < tsc_pkg::Q28_TWO_PI, "reduced angle not below 2pi")
    `TSC_ASSERT_NOW(a_folded_range, aclk, aresetn, vld_reg[2],
        y30_reg <= 31'd1686629716, "folded angle beyond pi/2")

endmodule

// File: rtl/tsc_cell.sv
// ----------------------------------------------------------------------------
// tsc_cell
// One Horner step: acc = round(acc * y2 / 2^30) + coefficient, two stages.
// ----------------------------------------------------------------------------
`include "taylor_sine_cosine_assert.svh"

module tsc_cell #(
    parameter logic signed [tsc_pkg::ACC_W-1:0] CELL_COEF = '0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  tsc_pkg::tsc_data_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tsc_pkg::tsc_data_t out_data
);

    localparam int PROD_W = tsc_pkg::ACC_W + tsc_pkg::Y2_W + 1;

    logic                       v1_reg, v2_reg;
    logic                       rdy1, rdy2;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic [tsc_pkg::Y2_W-1:0]   y2_reg;
    logic                       neg_reg;
    tsc_pkg::tsc_data_t         data_reg, data_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        prod_next = PROD_W'(in_data.acc) * PROD_W'($signed({1'b0, in_data.y2}));
        // arithmetic shift of the rounded product is floor division by 2^30
        prod_rnd       = prod_reg + PROD_W'(64'sd536870912);
        data_next.acc  = prod_rnd[tsc_pkg::ACC_W+29:30] + CELL_COEF;
        data_next.y2   = y2_reg;
        data_next.neg  = neg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            prod_reg <= prod_next;
            y2_reg   <= in_data.y2;
            neg_reg  <= in_data.neg;
        end
        if (rdy2 && v1_reg) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = data_reg;

    `TSC_ASSERT_NOW(a_acc_headroom, aclk, aresetn, v2_reg,
        data_reg.acc < 34'sd4294967296 && data_reg.acc > -34'sd4294967296,
        "Horner accumulator left its headroom")

endmodule

// File: rtl/taylor_sine_cosine.sv
// ----------------------------------------------------------------------------
// taylor_sine_cosine
// Streaming cosine/sine of a Q3.28 angle by an even Taylor series in Q1.30.
// ----------------------------------------------------------------------------
// Each request carries a signed Q3.28 angle in radians and an operation bit
// (0 cosine, 1 sine); each yields exactly one signed Q1.30 result, clamped to
// plus or minus one. The block is fully pipelined and takes one request per
// clock while the output is not stalled. The pipeline has five front stages
// (sine offset, reduction modulo 2pi, quadrant fold, squaring multiplier,
// rounding of the square), K = min(SERIES_TERMS/2, 7) Horner cells of two
// stages each (multiplier, then rounding shift plus coefficient), and the
// output register that clamps and applies the quadrant sign. Each stage holds
// its own valid bit, so bubbles are squeezed out while the output stalls, and
// s_ready drops only when every stage is full and m_ready is low. Sine is
// formed as cos(pi/2 - angle).
// ----------------------------------------------------------------------------
`include "taylor_sine_cosine_assert.svh"

module taylor_sine_cosine #(
    parameter int SERIES_TERMS = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_angle,
    input  logic               s_operation,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value
);

    // series order: odd terms are zero, and the table stops at x^14
    localparam int HALF_TERMS = SERIES_TERMS / 2;
    localparam int NCELL = (HALF_TERMS > tsc_pkg::MAX_TERM) ? tsc_pkg::MAX_TERM : HALF_TERMS;

    // chain links: index 0 is the front, index NCELL the last cell
    logic               link_valid [NCELL+1];
    logic               link_ready [NCELL+1];
    tsc_pkg::tsc_data_t link_data  [NCELL+1];

    logic                              m_valid_reg;
    logic signed [31:0]                m_value_reg, m_value_next;
    logic signed [tsc_pkg::ACC_W-1:0]  clamped, signed_val;
    logic                              out_rdy;

    // front end starts the accumulator at the highest coefficient in use
    tsc_front #(
        .INIT_COEF (tsc_pkg::COEF[NCELL])
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_angle     (s_angle),
        .in_operation (s_operation),
        .out_valid    (link_valid[0]),
        .out_ready    (link_ready[0]),
        .out_data     (link_data[0])
    );

    // one cell per remaining coefficient, highest order first
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        tsc_cell #(
            .CELL_COEF (tsc_pkg::COEF[NCELL-1-g])
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[g]),
            .in_ready  (link_ready[g]),
            .in_data   (link_data[g]),
            .out_valid (link_valid[g+1]),
            .out_ready (link_ready[g+1]),
            .out_data  (link_data[g+1])
        );
    end

    // output register: load whenever empty or being drained
    assign out_rdy            = !m_valid_reg || m_ready;
    assign link_ready[NCELL]  = out_rdy;

    always_comb begin
        // clamp to plus or minus one, then flip in quadrants II and III
        if (link_data[NCELL].acc > tsc_pkg::Q30_ONE) begin
            clamped = tsc_pkg::Q30_ONE;
        end else if (link_data[NCELL].acc < tsc_pkg::Q30_NEG_ONE) begin
            clamped = tsc_pkg::Q30_NEG_ONE;
        end else begin
            clamped = link_data[NCELL].acc;
        end
        signed_val   = link_data[NCELL].neg ? -clamped : clamped;
        m_value_next = signed_val[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_rdy) begin
            m_valid_reg <= link_valid[NCELL];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy && link_valid[NCELL]) begin
            m_value_reg <= m_value_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    `TSC_ASSERT_NOW(a_value_clamped, aclk, aresetn, m_valid,
        m_value <= 32'sd1073741824 && m_value >= -32'sd1073741824,
        "result outside plus or minus one")
    `TSC_ASSERT_NOW(a_ready_only_on_stall, aclk, aresetn, !s_ready,
        m_valid && !m_ready, "input blocked while output drains")

endmodule

// File: verif/taylor_sine_cosine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sine_cosine_test
// Self-checking bench for the streaming Taylor-series sine/cosine block.
// ----------------------------------------------------------------------------
// A scoreboard class predicts the clamped Q1.30 result of every accepted
// angle request. It does the range reduction, the quadrant fold and the
// Horner series in 64-bit integers. Each result that leaves the block is
// compared with the oldest prediction. The stimulus starts with directed
// angles: the field extremes and both sides of every quadrant boundary for
// cosine, and every quadrant boundary for sine. Random angles follow:
// full range, small angles and near-boundary angles, under four sender and
// receiver idle mixes. One long output hold-off fills the pipeline and
// stalls the input, and the sender drains the block between phases.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_test;

    localparam int     SERIES_TERMS  = 10;
    localparam int     PHASE_ITEMS   = 120;
    localparam int     HOLD_CYCLES   = 80;    // long output hold-off
    localparam int     SETTLE_CYCLES = 40;    // well past the pipeline latency
    localparam int     MAX_PRINTS    = 20;
    localparam longint TIMEOUT_NS    = 2_000_000;

    localparam longint Q28_HALF_PI  = 64'sd421657428;
    localparam longint Q28_PI       = 64'sd843314857;
    localparam longint Q28_3HALF_PI = 64'sd1264972285;
    localparam longint Q28_TWO_PI   = 64'sd1686629713;
    localparam longint Q30_ONE      = 64'sd1073741824;
    localparam longint Q30_HALF     = 64'sd536870912;
    localparam longint ANGLE_MAX    = 64'sd2147483647;
    localparam longint ANGLE_MIN    = -64'sd2147483648;

    // (-1)^k / (2k)! in Q.30, rounded to nearest
    localparam longint EVEN_TERM [8] = '{
        64'sd1073741824, -64'sd536870912, 64'sd44739243, -64'sd1491308,
        64'sd26631, -64'sd296, 64'sd2, 64'sd0
    };

    typedef enum bit {
        OP_COSINE = 1'b0,
        OP_SINE   = 1'b1
    } trig_op_e;

    typedef struct {
        logic signed [31:0] angle;
        trig_op_e           op;
        logic signed [31:0] value;
    } trig_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predict on each accepted request, check each result in order
    // ------------------------------------------------------------------------
    class sine_cosine_scoreboard;
        trig_result_t expected_values [$];
        int           mismatch_count;
        int           result_count;
        int           cosine_count;
        int           sine_count;
        int           quadrant_hits [4];

        function logic signed [31:0] predict_value(logic signed [31:0] angle, trig_op_e op,
                                                   output int quadrant);
            longint a;
            longint x;
            longint r;
            longint y;
            longint y30;
            longint y2;
            longint acc;
            int     top;
            a = angle;
            x = (op == OP_SINE) ? Q28_HALF_PI - a : a;
            r = x % Q28_TWO_PI;
            if (r < 0)
                r += Q28_TWO_PI;
            // fold into [0, pi/2] plus one LSB; exact boundaries go to the next quadrant
            if (r < Q28_HALF_PI) begin
                y = r;
                quadrant = 0;
            end else if (r < Q28_PI) begin
                y = Q28_PI - r;
                quadrant = 1;
            end else if (r < Q28_3HALF_PI) begin
                y = r - Q28_PI;
                quadrant = 2;
            end else begin
                y = Q28_TWO_PI - r;
                quadrant = 3;
            end
            y30 = y * 4;
            y2  = (y30 * y30 + Q30_HALF) >>> 30;
            top = SERIES_TERMS / 2;
            if (top > 7)
                top = 7;
            acc = EVEN_TERM[top];
            for (int k = top - 1; k >= 0; k--)
                acc = ((acc * y2 + Q30_HALF) >>> 30) + EVEN_TERM[k];
            if (acc > Q30_ONE)
                acc = Q30_ONE;
            if (acc < -Q30_ONE)
                acc = -Q30_ONE;
            if (quadrant == 1 || quadrant == 2)
                acc = -acc;
            return acc[31:0];
        endfunction

        function void note_request(logic signed [31:0] angle, trig_op_e op);
            trig_result_t item;
            int           quadrant;
            item.angle = angle;
            item.op    = op;
            item.value = predict_value(angle, op, quadrant);
            quadrant_hits[quadrant]++;
            if (op == OP_SINE)
                sine_count++;
            else
                cosine_count++;
            expected_values.push_back(item);
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        task report_mismatch(string what);
            if (mismatch_count < MAX_PRINTS)
                $display("tb: mismatch %0d at %0t ns: %s", mismatch_count + 1, $time, what);
            mismatch_count++;
        endtask

        task check_result(logic signed [31:0] value);
            trig_result_t want;
            result_count++;
            if (expected_values.size() == 0) begin
                report_mismatch($sformatf("result %0d with no request pending", value));
                return;
            end
            want = expected_values.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("%s of angle %0d: got %0d, predicted %0d",
                                          want.op.name(), want.angle, value, want.value));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_angle     = '0;
    logic               s_operation = 1'b0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic signed [31:0] m_value;

    sine_cosine_scoreboard sb = new();

    // idle mixes, set by the main sequence between phases
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // hold-off requests: the main sequence bumps the request count, the
    // receiver acknowledges it and counts the stall down on its own
    int hold_req_count = 0;
    int hold_ack_count = 0;
    int hold_left      = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    taylor_sine_cosine #(
        .SERIES_TERMS(SERIES_TERMS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_angle    (s_angle),
        .s_operation(s_operation),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value    (m_value)
    );

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off when one is requested
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req_count != hold_ack_count) begin
            hold_ack_count <= hold_req_count;
            hold_left      <= HOLD_CYCLES - 1;
            m_ready        <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Check every result at the edge that accepts it; values seen here are
    // the ones from before the edge, so no race with the block's registers.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_value);
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one request after a random idle gap; hold it until accepted.
    task automatic send_request(input logic signed [31:0] angle, input trig_op_e op);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_angle     <= angle;
        s_operation <= op;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_request(angle, op);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // Mix of full-range angles, small angles and angles a few LSBs away
    // from a quadrant boundary (boundaries taken on the cosine argument).
    function automatic logic signed [31:0] pick_angle(trig_op_e op);
        int unsigned pick;
        longint      a;
        pick = $urandom_range(9);
        if (pick < 4)
            return $urandom;
        if (pick < 7) begin
            a = longint'($urandom_range(32'h4000_0000)) - 64'sd536870912;
            return a[31:0];
        end
        case ($urandom_range(3))
            0: a = 0;
            1: a = Q28_HALF_PI;
            2: a = Q28_PI;
            default: a = Q28_3HALF_PI;
        endcase
        a += Q28_TWO_PI * (longint'($urandom_range(3)) - 2);
        a += longint'($urandom_range(16)) - 8;
        if (op == OP_SINE)
            a = Q28_HALF_PI - a;
        while (a > ANGLE_MAX)
            a -= Q28_TWO_PI;
        while (a < ANGLE_MIN)
            a += Q28_TWO_PI;
        return a[31:0];
    endfunction

    task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
        trig_op_e op;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < items; n++) begin
            op = trig_op_e'($urandom_range(1));
            send_request(pick_angle(op), op);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        longint cosine_angles [$];
        longint sine_angles [$];

        // extremes and both sides of each boundary; sine angles are chosen so
        // that pi/2 - angle lands on or next to the boundary
        cosine_angles = '{0, 1, -1, ANGLE_MAX, ANGLE_MIN,
                          Q28_HALF_PI - 1, Q28_HALF_PI, Q28_PI - 1, Q28_PI,
                          Q28_3HALF_PI - 1, Q28_3HALF_PI, Q28_TWO_PI - 1, Q28_TWO_PI,
                          -Q28_HALF_PI};
        sine_angles   = '{0, ANGLE_MAX, ANGLE_MIN, Q28_HALF_PI + 1,
                          Q28_HALF_PI - Q28_PI, Q28_HALF_PI - Q28_PI + 1,
                          Q28_HALF_PI - Q28_3HALF_PI, Q28_HALF_PI - Q28_TWO_PI};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, no idling
        foreach (cosine_angles[i])
            send_request(cosine_angles[i][31:0], OP_COSINE);
        foreach (sine_angles[i])
            send_request(sine_angles[i][31:0], OP_SINE);
        wait_drained();

        // back-to-back requests against a long output hold-off: the pipeline
        // fills and s_ready has to drop while valid keeps being offered
        hold_req_count <= hold_req_count + 1;
        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 59, 0);
        run_phase(PHASE_ITEMS, 0, 59);
        run_phase(PHASE_ITEMS, 14, 14);

        // catch anything that still trickles out
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("tb: %0d results checked (%0d cosine, %0d sine), quadrants %0d/%0d/%0d/%0d",
                 sb.result_count, sb.cosine_count, sb.sine_count, sb.quadrant_hits[0],
                 sb.quadrant_hits[1], sb.quadrant_hits[2], sb.quadrant_hits[3]);
        $display("tb: directed boundaries, four idle mixes and one long output stall");
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
